### hdl/calendar_field_editor_assert.svh
// assertion macros for the checker file
`ifndef CALENDAR_FIELD_EDITOR_ASSERT_SVH
`define CALENDAR_FIELD_EDITOR_ASSERT_SVH

// same-cycle implication, disabled while reset is held
`define CFE_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error("assertion failed");

// next-cycle implication, disabled while reset is held
`define CFE_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error("assertion failed");

`endif

### hdl/cfe_pkg.sv
// ----------------------------------------------------------------------------
// cfe_pkg
// shared types, op codes and the month length function of the field editor
// ----------------------------------------------------------------------------
package cfe_pkg;

    // op codes
    localparam logic [2:0] OP_LOAD = 3'd0;
    localparam logic [2:0] OP_NEXT = 3'd1;
    localparam logic [2:0] OP_DEC  = 3'd2;
    localparam logic [2:0] OP_INC  = 3'd3;
    localparam logic [2:0] OP_TICK = 3'd4;

    // field select codes
    localparam logic [2:0] SEL_YEAR    = 3'd0;
    localparam logic [2:0] SEL_MONTH   = 3'd1;
    localparam logic [2:0] SEL_DATE    = 3'd2;
    localparam logic [2:0] SEL_WEEKDAY = 3'd3;
    localparam logic [2:0] SEL_HOUR    = 3'd4;
    localparam logic [2:0] SEL_MINUTE  = 3'd5;
    localparam logic [2:0] SEL_SECOND  = 3'd6;

    localparam logic [6:0] YEAR_MAX   = 7'd99;
    localparam logic [3:0] MONTH_MAX  = 4'd12;
    localparam logic [2:0] WDAY_MAX   = 3'd7;
    localparam logic [4:0] HOUR_MAX   = 5'd23;
    localparam logic [5:0] MINSEC_MAX = 6'd59;

    localparam logic [9:0] BLINK_PERIOD_RESET = 10'd400;

    typedef struct packed {
        logic [6:0] year;
        logic [3:0] month;
        logic [4:0] date;
        logic [2:0] weekday;
        logic [4:0] hour;
        logic [5:0] minute;
        logic [5:0] second;
        logic [2:0] sel;
        logic       blink;
        logic [9:0] ticks;
    } t_cal;

    typedef struct packed {
        logic [6:0] year;
        logic [3:0] month;
        logic [4:0] date;
        logic [2:0] weekday;
        logic [4:0] hour;
        logic [5:0] minute;
        logic [5:0] second;
    } t_load;

    localparam logic [4:0] MONTH_LEN [16] = '{
        5'd31, 5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31,
        5'd31, 5'd30, 5'd31, 5'd30, 5'd31, 5'd31, 5'd31, 5'd31
    };

    // day-of-month limit; within 2000..2099 leap years are multiples of 4
    function automatic logic [4:0] day_limit(logic [6:0] year, logic [3:0] month);
        logic [4:0] lim;
        if (month == 4'd2) begin
            lim = (year[1:0] == 2'b00) ? 5'd29 : 5'd28;
        end else begin
            lim = MONTH_LEN[month];
        end
        return lim;
    endfunction

endpackage

### hdl/cfe_if.sv
// ----------------------------------------------------------------------------
// cfe_if
// valid/ready channels carrying field editor commands and snapshots
// ----------------------------------------------------------------------------
interface cfe_in_if;
    logic       valid;
    logic       ready;
    logic [2:0] op;
    logic [6:0] new_year;
    logic [3:0] new_month;
    logic [4:0] new_date;
    logic [2:0] new_weekday;
    logic [4:0] new_hour;
    logic [5:0] new_minute;
    logic [5:0] new_second;

    modport source (
        output valid, op, new_year, new_month, new_date, new_weekday,
               new_hour, new_minute, new_second,
        input  ready
    );
    modport sink (
        input  valid, op, new_year, new_month, new_date, new_weekday,
               new_hour, new_minute, new_second,
        output ready
    );
endinterface

interface cfe_out_if;
    logic       valid;
    logic       ready;
    logic [6:0] out_year;
    logic [3:0] out_month;
    logic [4:0] out_date;
    logic [2:0] out_weekday;
    logic [4:0] out_hour;
    logic [5:0] out_minute;
    logic [5:0] out_second;
    logic [2:0] out_select;
    logic       out_blink;

    modport source (
        output valid, out_year, out_month, out_date, out_weekday, out_hour,
               out_minute, out_second, out_select, out_blink,
        input  ready
    );
    modport sink (
        input  valid, out_year, out_month, out_date, out_weekday, out_hour,
               out_minute, out_second, out_select, out_blink,
        output ready
    );
endinterface

### hdl/cfe_update.sv
// ----------------------------------------------------------------------------
// cfe_update
// next calendar state for one command: load, select, step or blink tick
// ----------------------------------------------------------------------------
module cfe_update
    import cfe_pkg::*;
(
    input  t_cal       i_state,
    input  logic [2:0] i_op,
    input  t_load      i_load,
    input  logic [9:0] i_blink_period,
    output t_cal       o_state
);

    // wrap helpers on a common 7-bit width
    function automatic logic [6:0] inc_wrap(logic [6:0] v, logic [6:0] lo, logic [6:0] hi);
        logic [7:0] s;
        s = {1'b0, v} + 8'd1;
        return (s > {1'b0, hi}) ? lo : s[6:0];
    endfunction

    function automatic logic [6:0] dec_wrap(logic [6:0] v, logic [6:0] lo, logic [6:0] hi);
        logic [6:0] d;
        d = v - 7'd1;
        if (v <= lo) begin
            d = hi;
        end else if (d > hi) begin
            d = hi;
        end
        return d;
    endfunction

    function automatic logic [6:0] step(logic up, logic [6:0] v, logic [6:0] lo,
                                        logic [6:0] hi);
        return up ? inc_wrap(v, lo, hi) : dec_wrap(v, lo, hi);
    endfunction

    logic [6:0]  ld_year;
    logic [3:0]  ld_month;
    logic [4:0]  ld_lim;
    logic [4:0]  cur_lim;
    logic        up;
    logic [10:0] tick_next;
    logic [6:0]  stepped;

    always_comb begin
        ld_year  = (i_load.year > YEAR_MAX) ? YEAR_MAX : i_load.year;
        ld_month = (i_load.month == 4'd0) ? 4'd1 :
                   (i_load.month > MONTH_MAX) ? MONTH_MAX : i_load.month;
        ld_lim   = day_limit(ld_year, ld_month);
        cur_lim  = day_limit(i_state.year, i_state.month);
        up       = (i_op == OP_INC);
        tick_next = {1'b0, i_state.ticks} + 11'd1;
        stepped  = '0;

        o_state = i_state;
        unique case (i_op)
            OP_LOAD: begin
                o_state.year    = ld_year;
                o_state.month   = ld_month;
                o_state.date    = (i_load.date == 5'd0) ? 5'd1 :
                                  (i_load.date > ld_lim) ? ld_lim : i_load.date;
                o_state.weekday = (i_load.weekday == 3'd0) ? 3'd1 : i_load.weekday;
                o_state.hour    = (i_load.hour > HOUR_MAX) ? HOUR_MAX : i_load.hour;
                o_state.minute  = (i_load.minute > MINSEC_MAX) ? MINSEC_MAX
                                                               : i_load.minute;
                o_state.second  = (i_load.second > MINSEC_MAX) ? MINSEC_MAX
                                                               : i_load.second;
            end
            OP_NEXT: begin
                o_state.sel = (i_state.sel >= SEL_SECOND) ? SEL_YEAR : i_state.sel + 3'd1;
            end
            OP_DEC, OP_INC: begin
                unique case (i_state.sel)
                    SEL_YEAR: begin
                        o_state.year = step(up, i_state.year, 7'd0, YEAR_MAX);
                    end
                    SEL_MONTH: begin
                        stepped = step(up, {3'b0, i_state.month}, 7'd1, {3'b0, MONTH_MAX});
                        o_state.month = stepped[3:0];
                    end
                    SEL_DATE: begin
                        stepped = step(up, {2'b0, i_state.date}, 7'd1, {2'b0, cur_lim});
                        o_state.date = stepped[4:0];
                    end
                    SEL_WEEKDAY: begin
                        stepped = step(up, {4'b0, i_state.weekday}, 7'd1,
                                       {4'b0, WDAY_MAX});
                        o_state.weekday = stepped[2:0];
                    end
                    SEL_HOUR: begin
                        stepped = step(up, {2'b0, i_state.hour}, 7'd0, {2'b0, HOUR_MAX});
                        o_state.hour = stepped[4:0];
                    end
                    SEL_MINUTE: begin
                        stepped = step(up, {1'b0, i_state.minute}, 7'd0,
                                       {1'b0, MINSEC_MAX});
                        o_state.minute = stepped[5:0];
                    end
                    SEL_SECOND: begin
                        stepped = step(up, {1'b0, i_state.second}, 7'd0,
                                       {1'b0, MINSEC_MAX});
                        o_state.second = stepped[5:0];
                    end
                    default: begin
                    end
                endcase
            end
            OP_TICK: begin
                // a period of zero acts like one: toggle every tick
                if (tick_next >= {1'b0, i_blink_period}) begin
                    o_state.ticks = '0;
                    o_state.blink = ~i_state.blink;
                end else begin
                    o_state.ticks = tick_next[9:0];
                end
            end
            default: begin
            end
        endcase
    end

endmodule

### hdl/calendar_field_editor.sv
// ----------------------------------------------------------------------------
// calendar_field_editor
// date/time setting block with field select, wraparound stepping and blink
// ----------------------------------------------------------------------------
// usage
//   i_in  : command channel (op plus the load values); a transfer happens
//           when valid and ready are both high at a rising edge
//   o_out : snapshot channel; every command yields exactly one snapshot of
//           the date, time, selected field and blink flag after the command
//   i_cfg_we / i_cfg_wdata : write of the blink period, taken at any edge
//           with the write enable high; write only while the block is idle
//   latency: a snapshot is valid one cycle after its command transfer
//   throughput: one command per cycle; the single output register is
//           refilled in the same cycle that its snapshot is taken
//   stall: while the output snapshot waits, i_in.ready is low and the
//           calendar state (which is the snapshot itself) holds
//   reset: synchronous, active low; year 0 (2000), month 1, day 1, weekday
//           1, 00:00:00, year selected, blink off, blink period 400, no
//           snapshot pending
// ----------------------------------------------------------------------------
module calendar_field_editor
    import cfe_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    cfe_in_if.sink       i_in,
    cfe_out_if.source    o_out,
    input  logic         i_cfg_we,
    input  logic [9:0]   i_cfg_wdata
);

    // calendar state doubles as the output register payload
    t_cal       r_state;
    t_cal       n_state;
    logic       r_out_valid;
    logic [9:0] r_blink_period;
    t_load      load;
    logic       in_xfer;

    // accept whenever the output slot is empty or being emptied
    assign i_in.ready = ~r_out_valid | o_out.ready;
    assign in_xfer    = i_in.valid & i_in.ready;

    assign load = '{
        year:    i_in.new_year,
        month:   i_in.new_month,
        date:    i_in.new_date,
        weekday: i_in.new_weekday,
        hour:    i_in.new_hour,
        minute:  i_in.new_minute,
        second:  i_in.new_second
    };

    cfe_update u_update (
        .i_state        (r_state),
        .i_op           (i_in.op),
        .i_load         (load),
        .i_blink_period (r_blink_period),
        .o_state        (n_state)
    );

    // blink period register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_blink_period <= BLINK_PERIOD_RESET;
        end else if (i_cfg_we) begin
            r_blink_period <= i_cfg_wdata;
        end
    end

    // state and output valid: state moves only on an input transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_state     <= '{
                year: 7'd0, month: 4'd1, date: 5'd1, weekday: 3'd1,
                hour: 5'd0, minute: 6'd0, second: 6'd0,
                sel: SEL_YEAR, blink: 1'b0, ticks: 10'd0
            };
        end else begin
            if (in_xfer) begin
                r_state     <= n_state;
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // snapshot fields straight from the state
    assign o_out.valid       = r_out_valid;
    assign o_out.out_year    = r_state.year;
    assign o_out.out_month   = r_state.month;
    assign o_out.out_date    = r_state.date;
    assign o_out.out_weekday = r_state.weekday;
    assign o_out.out_hour    = r_state.hour;
    assign o_out.out_minute  = r_state.minute;
    assign o_out.out_second  = r_state.second;
    assign o_out.out_select  = r_state.sel;
    assign o_out.out_blink   = r_state.blink;

endmodule

### hdl/cfe_checker.sv
// ----------------------------------------------------------------------------
// cfe_checker
// port-level checks of the field editor, bound to the top level
// ----------------------------------------------------------------------------
`include "calendar_field_editor_assert.svh"

module cfe_checker
    import cfe_pkg::*;
(
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       i_in_ready,
    input logic [2:0] i_in_op,
    input logic [4:0] i_in_new_hour,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic [4:0] i_out_hour,
    input logic [2:0] i_out_select
);

    logic in_xfer;
    logic out_stall;
    logic hour_load;
    assign in_xfer   = i_in_valid & i_in_ready;
    assign out_stall = i_out_valid & ~i_out_ready;
    assign hour_load = in_xfer && (i_in_op == OP_LOAD) && (i_in_new_hour <= HOUR_MAX);

    // a stalled snapshot stays and holds its value
    `CFE_ASSERT_NEXT(a_out_hold, out_stall, i_out_valid && $stable(i_out_hour) && $stable(i_out_select))

    // every command transfer shows a snapshot the next cycle
    `CFE_ASSERT_NEXT(a_xfer_result, in_xfer, i_out_valid)

    // an empty output slot never blocks the command channel
    `CFE_ASSERT_NOW(a_ready_when_empty, !i_out_valid, i_in_ready)

    // an in-range hour load comes back unchanged
    `CFE_ASSERT_NEXT(a_load_hour, hour_load, i_out_hour == $past(i_in_new_hour))

endmodule

bind calendar_field_editor cfe_checker u_cfe_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_in.valid),
    .i_in_ready    (i_in.ready),
    .i_in_op       (i_in.op),
    .i_in_new_hour (i_in.new_hour),
    .i_out_valid   (o_out.valid),
    .i_out_ready   (o_out.ready),
    .i_out_hour    (o_out.out_hour),
    .i_out_select  (o_out.out_select)
);

### tb/sv/calendar_field_editor_test.sv
// ----------------------------------------------------------------------------
// calendar_field_editor_test
// self-checking bench for the date/time field editor: a short table of
// commands walks the extremes and wraparound cases, then randomized phases
// run under several blink periods; every snapshot is compared field by field
// with a hand-written one or a behavioral model tracking accepted commands
// ----------------------------------------------------------------------------
module calendar_field_editor_test;
    timeunit 1ns;
    timeprecision 1ps;

    import cfe_pkg::*;

    // op codes the block leaves without effect
    localparam logic [2:0] OP_RSVD5 = 3'd5;
    localparam logic [2:0] OP_RSVD7 = 3'd7;

    localparam int unsigned LONG_HOLD    = 300;   // receiver hold-off for backpressure
    localparam int unsigned IDLE_LIMIT   = 4000;  // cycles without any transfer
    localparam int unsigned DRAIN_CYCLES = 4;     // settle time after the last snapshot

    // one command as it sits on the input channel
    typedef struct packed {
        logic [2:0] op;
        t_load      ld;
    } cmd_t;

    // one snapshot as it sits on the output channel
    typedef struct packed {
        logic [6:0] year;
        logic [3:0] month;
        logic [4:0] date;
        logic [2:0] weekday;
        logic [4:0] hour;
        logic [5:0] minute;
        logic [5:0] second;
        logic [2:0] sel;
        logic       blink;
    } snap_t;

    // directed table row: command plus an optional hand-written snapshot
    typedef struct {
        cmd_t  cmd;
        logic  typed;
        snap_t want;
    } stim_row_t;

    logic       clk;
    logic       rst_n;
    logic       cfg_we;
    logic [9:0] cfg_wdata;

    // hand-written snapshot traveling alongside the command payload
    logic  hint_on;
    snap_t hint_snap;

    cfe_in_if  cmd_if ();
    cfe_out_if snap_if ();

    // model state, blink period and the snapshots still owed by the block
    t_cal        cal_model;
    logic [9:0]  period_model;
    snap_t       pending_snaps[$];
    int unsigned fail_count = 0;

    // pacing controls shared by the sender and the receiver
    bit idle_off;
    bit hold_req;

    calendar_field_editor DUT (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in        (cmd_if),
        .o_out       (snap_if),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata)
    );

    initial begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // calendar model
    // ------------------------------------------------------------------

    // days in a month; years 2000..2099, so every fourth year is a leap year
    function automatic int unsigned month_days(int unsigned year, int unsigned month);
        if (month == 2) begin
            return (year % 4 == 0) ? 29 : 28;
        end
        if (month == 4 || month == 6 || month == 9 || month == 11) begin
            return 30;
        end
        return 31;
    endfunction

    function automatic int unsigned clamp(int unsigned v, int unsigned lo, int unsigned hi);
        if (v < lo) begin
            return lo;
        end
        return (v > hi) ? hi : v;
    endfunction

    // one step up or down with wraparound; a value already past the top
    // steps down to the top and up to the bottom
    function automatic int unsigned step_wrap(int unsigned v, int unsigned lo,
                                              int unsigned hi, bit up);
        if (up) begin
            return (v + 1 > hi) ? lo : v + 1;
        end
        if (v <= lo) begin
            return hi;
        end
        return (v - 1 > hi) ? hi : v - 1;
    endfunction

    // calendar state after one command
    function automatic t_cal next_calendar(t_cal s, logic [9:0] period, cmd_t c);
        t_cal        n;
        bit          up;
        int unsigned cnt;
        n  = s;
        up = (c.op == OP_INC);
        case (c.op)
            OP_LOAD: begin
                // every field saturates; the day uses the loaded month and year
                n.year    = 7'(clamp(c.ld.year, 0, YEAR_MAX));
                n.month   = 4'(clamp(c.ld.month, 1, MONTH_MAX));
                n.date    = 5'(clamp(c.ld.date, 1, month_days(n.year, n.month)));
                n.weekday = 3'(clamp(c.ld.weekday, 1, WDAY_MAX));
                n.hour    = 5'(clamp(c.ld.hour, 0, HOUR_MAX));
                n.minute  = 6'(clamp(c.ld.minute, 0, MINSEC_MAX));
                n.second  = 6'(clamp(c.ld.second, 0, MINSEC_MAX));
            end
            OP_NEXT: begin
                n.sel = (s.sel == SEL_SECOND) ? SEL_YEAR : s.sel + 3'd1;
            end
            OP_DEC, OP_INC: begin
                case (s.sel)
                    SEL_YEAR:    n.year    = 7'(step_wrap(s.year, 0, YEAR_MAX, up));
                    SEL_MONTH:   n.month   = 4'(step_wrap(s.month, 1, MONTH_MAX, up));
                    SEL_DATE:    n.date    = 5'(step_wrap(s.date, 1,
                                                month_days(s.year, s.month), up));
                    SEL_WEEKDAY: n.weekday = 3'(step_wrap(s.weekday, 1, WDAY_MAX, up));
                    SEL_HOUR:    n.hour    = 5'(step_wrap(s.hour, 0, HOUR_MAX, up));
                    SEL_MINUTE:  n.minute  = 6'(step_wrap(s.minute, 0, MINSEC_MAX, up));
                    SEL_SECOND:  n.second  = 6'(step_wrap(s.second, 0, MINSEC_MAX, up));
                    default: ;
                endcase
            end
            OP_TICK: begin
                // a period of zero acts like one; a count left above a newly
                // lowered period wraps on the next tick
                cnt = s.ticks + 1;
                if (cnt >= period) begin
                    n.ticks = '0;
                    n.blink = ~s.blink;
                end else begin
                    n.ticks = 10'(cnt);
                end
            end
            default: ;
        endcase
        return n;
    endfunction

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------

    function automatic cmd_t mk_cmd(logic [2:0] op, int unsigned y, int unsigned m,
                                    int unsigned d, int unsigned w, int unsigned h,
                                    int unsigned mi, int unsigned s);
        cmd_t c;
        c.op         = op;
        c.ld.year    = 7'(y);
        c.ld.month   = 4'(m);
        c.ld.date    = 5'(d);
        c.ld.weekday = 3'(w);
        c.ld.hour    = 5'(h);
        c.ld.minute  = 6'(mi);
        c.ld.second  = 6'(s);
        return c;
    endfunction

    function automatic snap_t mk_snap(int unsigned y, int unsigned m, int unsigned d,
                                      int unsigned w, int unsigned h, int unsigned mi,
                                      int unsigned s, logic [2:0] sel, bit blink);
        return '{7'(y), 4'(m), 5'(d), 3'(w), 5'(h), 6'(mi), 6'(s), sel, blink};
    endfunction

    // table row left to the model
    function automatic stim_row_t op_row(logic [2:0] op);
        return '{mk_cmd(op, 0, 0, 0, 0, 0, 0, 0), 1'b0, '0};
    endfunction

    // idle length: mostly none, some short, a few long
    function automatic int unsigned pick_gap();
        int unsigned r;
        if (idle_off) begin
            return 0;
        end
        r = $urandom_range(99);
        if (r < 60) begin
            return 0;
        end
        if (r < 92) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    function automatic cmd_t random_cmd(int unsigned tick_pct);
        cmd_t        c;
        logic [63:0] raw;
        int unsigned r;
        // full-width noise on the payload, ignored unless the op is a load
        raw  = {$urandom, $urandom};
        c.ld = raw[$bits(t_load)-1:0];
        r    = $urandom_range(99);
        if ($urandom_range(99) < tick_pct) begin
            c.op = OP_TICK;
        end else if (r < 4) begin
            c.op = 3'($urandom_range(OP_RSVD5, OP_RSVD7));
        end else if (r < 30) begin
            c.op = OP_LOAD;
        end else if (r < 50) begin
            c.op = OP_NEXT;
        end else if (r < 75) begin
            c.op = OP_DEC;
        end else begin
            c.op = OP_INC;
        end
        // most loads are legal, with february and month-end days favored
        if (c.op == OP_LOAD && $urandom_range(9) >= 2) begin
            c.ld.year    = 7'($urandom_range(YEAR_MAX));
            c.ld.month   = ($urandom_range(3) == 0) ? 4'd2 : 4'($urandom_range(1, MONTH_MAX));
            c.ld.date    = ($urandom_range(1) == 0) ? 5'($urandom_range(28, 31))
                                                    : 5'($urandom_range(1, 31));
            c.ld.weekday = 3'($urandom_range(1, WDAY_MAX));
            c.ld.hour    = 5'($urandom_range(HOUR_MAX));
            c.ld.minute  = 6'($urandom_range(MINSEC_MAX));
            c.ld.second  = 6'($urandom_range(MINSEC_MAX));
        end
        return c;
    endfunction

    // offer one command and hold it until the transfer happens
    task automatic send_cmd(input cmd_t c, input logic typed, input snap_t want);
        int unsigned gap;
        gap = pick_gap();
        if (gap != 0) begin
            cmd_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        cmd_if.valid       <= 1'b1;
        cmd_if.op          <= c.op;
        cmd_if.new_year    <= c.ld.year;
        cmd_if.new_month   <= c.ld.month;
        cmd_if.new_date    <= c.ld.date;
        cmd_if.new_weekday <= c.ld.weekday;
        cmd_if.new_hour    <= c.ld.hour;
        cmd_if.new_minute  <= c.ld.minute;
        cmd_if.new_second  <= c.ld.second;
        hint_on            <= typed;
        hint_snap          <= want;
        @(posedge clk);
        while (!cmd_if.ready) @(posedge clk);
    endtask

    // blink period write, only once every owed snapshot has come back
    task automatic write_period(input logic [9:0] value);
        cmd_if.valid <= 1'b0;
        @(posedge clk);
        while (pending_snaps.size() != 0) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    // one random phase; only ops with an effect count toward its length
    task automatic run_phase(input logic [9:0] period, input int unsigned n_items,
                             input int unsigned tick_pct, input bit quiet,
                             input bit squeeze);
        int unsigned sent;
        cmd_t        c;
        write_period(period);
        idle_off = quiet;
        // receiver goes silent while commands keep coming
        if (squeeze) begin
            hold_req = 1'b1;
        end
        sent = 0;
        while (sent < n_items) begin
            c = random_cmd(tick_pct);
            send_cmd(c, 1'b0, '0);
            if (c.op <= OP_TICK) begin
                sent++;
            end
        end
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            fail_count++;
        end
    endtask

    // ------------------------------------------------------------------
    // scoreboard: model update on each command transfer, compare on each
    // snapshot transfer; values are sampled as they stood before the edge
    // ------------------------------------------------------------------
    always @(posedge clk) begin : scoreboard
        cmd_t  c;
        snap_t got;
        snap_t want;
        if (!rst_n) begin
            cal_model         = '0;
            cal_model.month   = 4'd1;
            cal_model.date    = 5'd1;
            cal_model.weekday = 3'd1;
            period_model      = BLINK_PERIOD_RESET;
            pending_snaps.delete();
        end else begin
            if (cfg_we) begin
                period_model = cfg_wdata;
            end
            // snapshots first: a snapshot never belongs to a command of the same edge
            if (snap_if.valid && snap_if.ready) begin
                got = '{snap_if.out_year, snap_if.out_month, snap_if.out_date,
                        snap_if.out_weekday, snap_if.out_hour, snap_if.out_minute,
                        snap_if.out_second, snap_if.out_select, snap_if.out_blink};
                if (pending_snaps.size() == 0) begin
                    $display("%0t: snapshot with nothing expected, expected none, actual %p",
                             $time, got);
                    fail_count++;
                end else begin
                    want = pending_snaps.pop_front();
                    check_field("year", want.year, got.year);
                    check_field("month", want.month, got.month);
                    check_field("date", want.date, got.date);
                    check_field("weekday", want.weekday, got.weekday);
                    check_field("hour", want.hour, got.hour);
                    check_field("minute", want.minute, got.minute);
                    check_field("second", want.second, got.second);
                    check_field("select", want.sel, got.sel);
                    check_field("blink", want.blink, got.blink);
                end
            end
            if (cmd_if.valid && cmd_if.ready) begin
                c.op         = cmd_if.op;
                c.ld.year    = cmd_if.new_year;
                c.ld.month   = cmd_if.new_month;
                c.ld.date    = cmd_if.new_date;
                c.ld.weekday = cmd_if.new_weekday;
                c.ld.hour    = cmd_if.new_hour;
                c.ld.minute  = cmd_if.new_minute;
                c.ld.second  = cmd_if.new_second;
                cal_model    = next_calendar(cal_model, period_model, c);
                want = '{cal_model.year, cal_model.month, cal_model.date,
                         cal_model.weekday, cal_model.hour, cal_model.minute,
                         cal_model.second, cal_model.sel, cal_model.blink};
                // a hand-written snapshot takes the place of the model's
                if (hint_on) begin
                    want = hint_snap;
                end
                pending_snaps.push_back(want);
            end
        end
    end

    // ------------------------------------------------------------------
    // receiver pacing: random ready runs, plus one long hold-off on request
    // ------------------------------------------------------------------
    initial begin : sink_pacing
        int unsigned run_left;
        int unsigned hold_left;
        int unsigned g;
        bit          level;
        snap_if.ready = 1'b0;
        run_left      = 0;
        hold_left     = 0;
        level         = 1'b0;
        forever begin
            @(posedge clk);
            if (hold_req && hold_left == 0) begin
                hold_req  = 1'b0;
                hold_left = LONG_HOLD;
            end
            if (hold_left != 0) begin
                hold_left--;
                snap_if.ready <= 1'b0;
            end else begin
                if (run_left == 0) begin
                    g = level ? pick_gap() : 0;
                    if (g == 0) begin
                        level    = 1'b1;
                        run_left = $urandom_range(1, 12);
                    end else begin
                        level    = 1'b0;
                        run_left = g;
                    end
                end
                run_left--;
                snap_if.ready <= level;
            end
        end
    end

    // ------------------------------------------------------------------
    // watchdog: ends the run when no transfer happens for too long
    // ------------------------------------------------------------------
    initial begin : watchdog
        int unsigned stall_cycles;
        stall_cycles = 0;
        while (stall_cycles < IDLE_LIMIT) begin
            @(posedge clk);
            if (!rst_n || (cmd_if.valid && cmd_if.ready) ||
                (snap_if.valid && snap_if.ready)) begin
                stall_cycles = 0;
            end else begin
                stall_cycles++;
            end
        end
        $display("%0t: no transfer for %0d cycles", $time, IDLE_LIMIT);
        $display("CHECK FAILED");
        $finish;
    end

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------
    initial begin : stimulus
        stim_row_t directed_rows[$];

        // every block input known from time zero
        rst_n              = 1'b0;
        cfg_we             = 1'b0;
        cfg_wdata          = '0;
        cmd_if.valid       = 1'b0;
        cmd_if.op          = OP_LOAD;
        cmd_if.new_year    = '0;
        cmd_if.new_month   = '0;
        cmd_if.new_date    = '0;
        cmd_if.new_weekday = '0;
        cmd_if.new_hour    = '0;
        cmd_if.new_minute  = '0;
        cmd_if.new_second  = '0;
        hint_on            = 1'b0;
        hint_snap          = '0;
        idle_off           = 1'b0;
        hold_req           = 1'b0;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // reset state, unused op, year wrap both ways
        directed_rows.push_back('{mk_cmd(OP_RSVD7, 0, 0, 0, 0, 0, 0, 0), 1'b1,
                                  mk_snap(0, 1, 1, 1, 0, 0, 0, SEL_YEAR, 0)});
        directed_rows.push_back('{mk_cmd(OP_DEC, 0, 0, 0, 0, 0, 0, 0), 1'b1,
                                  mk_snap(99, 1, 1, 1, 0, 0, 0, SEL_YEAR, 0)});
        directed_rows.push_back('{mk_cmd(OP_INC, 0, 0, 0, 0, 0, 0, 0), 1'b1,
                                  mk_snap(0, 1, 1, 1, 0, 0, 0, SEL_YEAR, 0)});
        // loads: all ones saturate high, all zeros saturate low
        directed_rows.push_back('{mk_cmd(OP_LOAD, 127, 15, 31, 7, 31, 63, 63), 1'b1,
                                  mk_snap(99, 12, 31, 7, 23, 59, 59, SEL_YEAR, 0)});
        directed_rows.push_back('{mk_cmd(OP_LOAD, 0, 0, 0, 0, 0, 0, 0), 1'b1,
                                  mk_snap(0, 1, 1, 1, 0, 0, 0, SEL_YEAR, 0)});
        // february day limit in a leap year and in a common year
        directed_rows.push_back('{mk_cmd(OP_LOAD, 0, 2, 31, 3, 12, 30, 45), 1'b1,
                                  mk_snap(0, 2, 29, 3, 12, 30, 45, SEL_YEAR, 0)});
        directed_rows.push_back('{mk_cmd(OP_LOAD, 1, 2, 30, 6, 23, 59, 59), 1'b1,
                                  mk_snap(1, 2, 28, 6, 23, 59, 59, SEL_YEAR, 0)});
        directed_rows.push_back('{mk_cmd(OP_LOAD, 4, 2, 29, 1, 0, 0, 0), 1'b1,
                                  mk_snap(4, 2, 29, 1, 0, 0, 0, SEL_YEAR, 0)});
        // year step leaves the 29th past the limit; then step the day down
        directed_rows.push_back(op_row(OP_INC));
        directed_rows.push_back(op_row(OP_NEXT));
        directed_rows.push_back(op_row(OP_NEXT));
        directed_rows.push_back(op_row(OP_DEC));
        // decrement at the minimum of weekday, hour, minute and second
        directed_rows.push_back(op_row(OP_NEXT));
        directed_rows.push_back(op_row(OP_DEC));
        directed_rows.push_back(op_row(OP_NEXT));
        directed_rows.push_back(op_row(OP_DEC));
        directed_rows.push_back(op_row(OP_NEXT));
        directed_rows.push_back(op_row(OP_DEC));
        directed_rows.push_back(op_row(OP_NEXT));
        directed_rows.push_back(op_row(OP_DEC));
        // selection wraps from second to year, then on to month
        directed_rows.push_back(op_row(OP_NEXT));
        directed_rows.push_back(op_row(OP_NEXT));
        directed_rows.push_back('{mk_cmd(OP_LOAD, 5, 3, 31, 7, 23, 59, 59), 1'b1,
                                  mk_snap(5, 3, 31, 7, 23, 59, 59, SEL_MONTH, 0)});
        // month step leaves the 31st past the limit; increment gives 1, then
        // a decrement from 1 wraps to the limit
        directed_rows.push_back(op_row(OP_DEC));
        directed_rows.push_back(op_row(OP_NEXT));
        directed_rows.push_back(op_row(OP_INC));
        directed_rows.push_back(op_row(OP_DEC));

        foreach (directed_rows[i]) begin
            send_cmd(directed_rows[i].cmd, directed_rows[i].typed, directed_rows[i].want);
        end

        // random phases: period zero, one with backpressure, the top with
        // heavy ticking, a small one below the count left behind, a random
        // one without idling, and back to the reset value
        run_phase(10'd0, 100, 30, 1'b0, 1'b0);
        run_phase(10'd1, 80, 25, 1'b1, 1'b1);
        run_phase(10'd1023, 250, 70, 1'b0, 1'b0);
        run_phase(10'd3, 100, 25, 1'b0, 1'b0);
        run_phase(10'($urandom_range(2, 1022)), 150, 30, 1'b1, 1'b0);
        run_phase(BLINK_PERIOD_RESET, 120, 25, 1'b0, 1'b0);

        // drain the owed snapshots, then watch for strays
        cmd_if.valid <= 1'b0;
        @(posedge clk);
        while (pending_snaps.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (fail_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

### calendar_field_editor.f
+incdir+hdl
hdl/cfe_pkg.sv
hdl/cfe_if.sv
hdl/cfe_update.sv
hdl/calendar_field_editor.sv
hdl/cfe_checker.sv
tb/sv/calendar_field_editor_test.sv
